// ===== src/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg
// Shared constants and codes for the multiset counting table.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int COUNT_BITS    = 16;
	localparam int KEY_BITS      = 32;
	localparam int KIND_BITS     = 2;
	localparam int OUT_CNT_BITS  = 16;

	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);
	localparam int ENTRY_BITS    = KEY_BITS + COUNT_BITS;

	// s_tdata: key; s_tuser: kind
	localparam int S_TDATA_BITS  = 32;
	localparam int S_TUSER_BITS  = 2;
	// m_tdata: ever_added, count, table_full, zero pad
	localparam int M_TDATA_BITS  = 24;

	localparam logic [KIND_BITS-1:0] KIND_ADD = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_ASK = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_DEL = 2'd2;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

endpackage

// ===== src/multiset_count_table.sv =====
// ----------------------------------------------------------------------------
// multiset_count_table
// Keyed counting table: add, ask and delete-all on signed 32-bit keys.
// ----------------------------------------------------------------------------
// Each item carries a key on s_tdata and a kind on s_tuser (0 add, 1 ask,
// 2 delete all copies, 3 ignored with an all-zero result) and produces exactly
// one result item. Keys and counts live in one RAM (key in the upper bits,
// count in the lower bits) whose entries are allocated in order and never
// freed, so a fill count (used_q) marks the valid part and no clearing
// pass is needed after reset. A lookup scans the RAM from entry 0, one entry
// per cycle with the read pipelined against the compare. An item that hits
// at entry i ends the scan there; a miss (including any add of a new key)
// scans every allocated entry. The single RAM read port sets the scan time.
// A finished result that finds the output register still full waits in
// ST_DONE until it is taken. One item is in work at a time; a finished
// result waits in the output register while the next item is taken.
// Counts saturate at all ones. An add of a new key into a full table leaves
// the state alone and reports table_full.
module multiset_count_table
	import mct_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,  // [31:0] key
	input  logic [S_TUSER_BITS-1:0] s_tuser,  // [1:0] kind
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata   // [0] ever_added, [16:1] count,
	                                          // [17] table_full, [23:18] zero
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [KIND_BITS-1:0]  kind_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [USED_BITS-1:0]  used_q;   // entries allocated so far
	logic [USED_BITS-1:0]  addr_q;   // next entry to read
	logic                  dvld_q;   // RAM output holds entry didx_q
	logic [IDX_BITS-1:0]   didx_q;

	// finished result, waiting for the output register
	logic                  ever_q;
	logic                  full_q;
	logic [COUNT_BITS-1:0] cnt_q;

	// RAM port
	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic [ENTRY_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [IDX_BITS-1:0]   ram_raddr;
	logic [ENTRY_BITS-1:0] ram_rdata;

	logic [KEY_BITS-1:0]   rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  hit;
	logic                  more;
	logic                  room;
	logic                  s_accept;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	assign rd_key  = ram_rdata[ENTRY_BITS-1 -: KEY_BITS];
	assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
	assign cnt_inc = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
	assign hit     = dvld_q && (rd_key == key_q);
	assign more    = (addr_q < used_q);
	assign room    = (used_q < USED_BITS'(TABLE_ENTRIES));

	// RAM control: reads walk the allocated entries, at most one write at the end
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = addr_q[IDX_BITS-1:0];
		ram_we    = 1'b0;
		ram_waddr = didx_q;
		ram_wdata = {key_q, rd_cnt};
		case (state_q)
			ST_IDLE: begin
				ram_re    = s_accept;
				ram_raddr = '0;
			end
			ST_SCAN: begin
				if (hit) begin
					case (kind_q)
						KIND_ADD: begin
							ram_we    = 1'b1;
							ram_wdata = {key_q, cnt_inc};
						end
						KIND_DEL: begin
							ram_we    = 1'b1;
							ram_wdata = {key_q, COUNT_BITS'(0)};
						end
						default: ;
					endcase
				end else if (more) begin
					ram_re = 1'b1;
				end else if (kind_q == KIND_ADD && room) begin
					// new key goes to the next free entry
					ram_we    = 1'b1;
					ram_waddr = used_q[IDX_BITS-1:0];
					ram_wdata = {key_q, COUNT_BITS'(1)};
				end
			end
			default: ;
		endcase
	end

	mct_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= '0;
			key_q    <= '0;
			used_q   <= '0;
			addr_q   <= '0;
			dvld_q   <= 1'b0;
			didx_q   <= '0;
			ever_q   <= 1'b0;
			full_q   <= 1'b0;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			// in ST_DONE the output register is reloaded instead
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= s_tuser;
						key_q   <= s_tdata;
						addr_q  <= USED_BITS'(1);
						dvld_q  <= (used_q != '0);
						didx_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						full_q <= 1'b0;
						case (kind_q)
							KIND_ADD: begin
								ever_q <= 1'b1;
								cnt_q  <= cnt_inc;
							end
							KIND_ASK, KIND_DEL: begin
								// count before the delete
								ever_q <= 1'b1;
								cnt_q  <= rd_cnt;
							end
							default: begin
								ever_q <= 1'b0;
								cnt_q  <= '0;
							end
						endcase
						state_q <= ST_DONE;
					end else if (more) begin
						addr_q <= addr_q + USED_BITS'(1);
						dvld_q <= 1'b1;
						didx_q <= addr_q[IDX_BITS-1:0];
					end else begin
						// key not in table
						ever_q <= 1'b0;
						full_q <= 1'b0;
						cnt_q  <= '0;
						if (kind_q == KIND_ADD) begin
							if (room) begin
								used_q <= used_q + USED_BITS'(1);
								ever_q <= 1'b1;
								cnt_q  <= COUNT_BITS'(1);
							end else begin
								full_q <= 1'b1;
							end
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= M_TDATA_BITS'({full_q, OUT_CNT_BITS'(cnt_q), ever_q});
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/mct_ram.sv =====
// ----------------------------------------------------------------------------
// mct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/mct_checker.sv =====
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks for the multiset counting table, bound to the top level.
// ----------------------------------------------------------------------------
module mct_checker
	import mct_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic [S_TDATA_BITS-1:0] s_tdata,
	input logic [S_TUSER_BITS-1:0] s_tuser,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [M_TDATA_BITS-1:0] m_tdata
);

	logic       s_acc;
	logic       m_acc;
	logic [1:0] pend_q;  // items taken, result not yet delivered

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s_acc && !m_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (m_acc && !s_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// at most one item in work plus one waiting result
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more items outstanding than the block can hold");

	// no result without an item behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result item without an accepted input item");

	// a failed add reports nothing else
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17]) |-> (m_tdata[16:0] == 17'd0))
		else $error("table_full with nonzero ever_added or count");

	// an unknown key has no count
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[16:1] == 16'd0))
		else $error("nonzero count for a key never added");

endmodule

bind multiset_count_table mct_checker u_mct_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
